// ===== rtl/dsrl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_pkg
// Shared types and codes for the depth-sorted render list unit.
// ----------------------------------------------------------------------------
package dsrl_pkg;

   localparam int KEY_W = 34;
   localparam int ID_W  = 32;
   localparam int CRD_W = 16;

   localparam logic [1:0] CSR_CAM_X = 2'd0;
   localparam logic [1:0] CSR_CAM_Y = 2'd1;
   localparam logic [1:0] CSR_CAM_Z = 2'd2;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_SKIPPED = 3'd1,
      ST_DROPPED = 3'd2,
      ST_ENTRY   = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIST,
      S_INS,
      S_RESP,
      S_READ
   } state_type;

   // Per-cell control, broadcast from the sequencer along the row.
   typedef struct packed {
      logic             clear;
      logic             insert;
      logic             shift;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/depth_sorted_render_lists_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depth_sorted_render_lists_unit
// Bounded depth-sorted draw lists keyed by squared camera distance.
// ----------------------------------------------------------------------------
//  channel  | direction | words
//  req_     | in        | clear / insert / read request
//  rsp_     | out       | one word per clear or insert, one per entry on read (one if empty)
//  csr_     | in        | camera position writes
//
//  Clear and skipped insert: response the cycle after accept. Insert:
//  difference, square and sum are registered in turn, then the response
//  and compare-and-shift in every target list; no accept until it ends.
//  Read: each word is emitted, then the list rotates; back to idle after
//  the last entry. Reset empties all lists at once.
//  A stalled response holds the sequencer.
// ----------------------------------------------------------------------------
module depth_sorted_render_lists_unit #(
   parameter int LIST_DEPTH    = 32,
   parameter int OUTLINE_LISTS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_req_type,
   input  wire logic [31:0] req_mesh_id,
   input  wire logic signed [15:0] req_center_x,
   input  wire logic signed [15:0] req_center_y,
   input  wire logic signed [15:0] req_center_z,
   input  wire logic        req_is_active,
   input  wire logic        req_is_visible,
   input  wire logic        req_has_material,
   input  wire logic        req_is_transparent,
   input  wire logic        req_is_outlined,
   input  wire logic [1:0]  req_outline_kind,
   input  wire logic [2:0]  req_list_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_mesh_id,
   output logic [33:0]      rsp_out_distance,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);
   import dsrl_pkg::*;

   localparam int NL  = 2 + OUTLINE_LISTS;
   localparam int CW  = $clog2(LIST_DEPTH + 1);

   logic signed [15:0] cam_ff [3];
   state_type          st_ff, st_in;
   logic [ID_W-1:0]    id_ff;
   logic [15:0]        d_ff [3];
   logic [31:0]        sq_ff [3];
   logic [KEY_W-1:0]   key_ff;
   logic [NL-1:0]      tgt_ff;
   logic [2:0]         sel_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rv_ff, rv_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [KEY_W-1:0]   rkey_ff, rkey_in;
   status_type         rst_ff, rst_in;
   logic               rl_ff, rl_in;
   logic               step_ff, step_in;

   logic [NL-1:0]              drop;
   logic [NL-1:0][CW-1:0]      cnt_l;
   logic [NL-1:0][ID_W-1:0]    hid;
   logic [NL-1:0][KEY_W-1:0]   hkey;
   logic                       take, out_free, drop_any, ins_ok;
   logic [NL-1:0]              tgt_in;
   logic signed [16:0]         dif [3];
   logic [15:0]                mag [3];
   logic [CW-1:0]              n_sel;
   logic [ID_W-1:0]            hid_sel;
   logic [KEY_W-1:0]           hkey_sel;

   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign take      = req_valid && req_ready;
   assign ins_ok    = req_is_active && req_is_visible && req_has_material;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff[0] <= '0;
         cam_ff[1] <= '0;
         cam_ff[2] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAM_X: cam_ff[0] <= csr_data;
            CSR_CAM_Y: cam_ff[1] <= csr_data;
            CSR_CAM_Z: cam_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      dif[0] = 17'(req_center_x) - 17'(cam_ff[0]);
      dif[1] = 17'(req_center_y) - 17'(cam_ff[1]);
      dif[2] = 17'(req_center_z) - 17'(cam_ff[2]);
      for (int i = 0; i < 3; i++) begin
         mag[i] = dif[i][16] ? 16'(-dif[i]) : 16'(dif[i]);
      end
   end

   always_comb begin
      tgt_in = '0;
      if (req_is_transparent) tgt_in[1] = 1'b1;
      else                    tgt_in[0] = 1'b1;
      for (int k = 0; k < OUTLINE_LISTS; k++) begin
         if (req_is_outlined && int'(req_outline_kind) == k) tgt_in[2 + k] = 1'b1;
      end
   end

   for (genvar l = 0; l < NL; l++) begin : g_list
      cell_ctl_type ctl;
      always_comb begin
         ctl.clear  = take && req_req_type == REQ_CLEAR;
         ctl.insert = st_ff == S_INS && tgt_ff[l];
         ctl.shift  = st_ff == S_READ && step_ff && int'(sel_ff) == l;
         ctl.id     = id_ff;
         ctl.key    = key_ff;
      end
      dsrl_list #(.DEPTH(LIST_DEPTH)) u_list (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .descending (l != 0),
         .tail_drop  (drop[l]),
         .count      (cnt_l[l]),
         .head_id    (hid[l]),
         .head_key   (hkey[l])
      );
   end

   assign drop_any = |(drop & tgt_ff);

   always_comb begin
      n_sel    = '0;
      hid_sel  = '0;
      hkey_sel = '0;
      for (int l = 0; l < NL; l++) begin
         if (int'(sel_ff) == l) begin
            n_sel    = cnt_l[l];
            hid_sel  = hid[l];
            hkey_sel = hkey[l];
         end
      end
   end

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      step_in = 1'b0;
      rv_in   = rv_ff && !rsp_ready;
      rst_in  = rst_ff;
      rl_in   = rl_ff;
      rid_in  = rid_ff;
      rkey_in = rkey_ff;
      case (st_ff)
         S_IDLE: begin
            if (take) begin
               cnt_in = '0;
               case (req_kind_type'(req_req_type))
                  REQ_CLEAR: begin
                     rv_in = 1'b1; rst_in = ST_DONE; rl_in = 1'b1;
                     rid_in = '0; rkey_in = '0;
                  end
                  REQ_INSERT: begin
                     if (ins_ok) begin
                        st_in = S_DIST;
                     end else begin
                        rv_in = 1'b1; rst_in = ST_SKIPPED; rl_in = 1'b1;
                        rid_in = '0; rkey_in = '0;
                     end
                  end
                  REQ_READ: st_in = S_READ;
                  default: ;
               endcase
            end
         end
         S_DIST: st_in = S_RESP;
         S_RESP: begin
            st_in = S_INS;
            rv_in = 1'b1; rl_in = 1'b1; rid_in = '0; rkey_in = '0;
            rst_in = drop_any ? ST_DROPPED : ST_DONE;
         end
         S_INS:  st_in = S_IDLE;
         S_READ: begin
            if (!step_ff) begin
               if (n_sel == '0) begin
                  if (out_free) begin
                     rv_in = 1'b1; rst_in = ST_EMPTY; rl_in = 1'b1;
                     rid_in = '0; rkey_in = '0;
                     st_in = S_IDLE;
                  end
               end else if (cnt_ff == n_sel) begin
                  st_in = S_IDLE;
               end else if (out_free) begin
                  rv_in   = 1'b1;
                  rst_in  = ST_ENTRY;
                  rid_in  = hid_sel;
                  rkey_in = hkey_sel;
                  rl_in   = (cnt_ff + CW'(1)) == n_sel;
                  step_in = 1'b1;
                  cnt_in  = cnt_ff + CW'(1);
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         rv_ff   <= 1'b0;
         step_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         rv_ff   <= rv_in;
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
      rst_ff  <= rst_in;
      rl_ff   <= rl_in;
      rid_ff  <= rid_in;
      rkey_ff <= rkey_in;
      if (take) begin
         id_ff   <= req_mesh_id;
         tgt_ff  <= tgt_in;
         sel_ff  <= req_list_select;
         d_ff[0] <= mag[0];
         d_ff[1] <= mag[1];
         d_ff[2] <= mag[2];
      end
      if (st_ff == S_DIST) begin
         sq_ff[0] <= 32'(d_ff[0]) * 32'(d_ff[0]);
         sq_ff[1] <= 32'(d_ff[1]) * 32'(d_ff[1]);
         sq_ff[2] <= 32'(d_ff[2]) * 32'(d_ff[2]);
      end
      if (st_ff == S_RESP) begin
         key_ff <= 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_out_mesh_id  = rid_ff;
   assign rsp_out_distance = rkey_ff;
   assign rsp_status       = rst_ff;
   assign rsp_last         = rl_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while word pending");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == S_INS |-> !req_ready) else $error("accept during insert");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DIST |=> st_ff == S_RESP) else $error("insert sequence");

endmodule
`default_nettype wire

// ===== rtl/dsrl_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_cell
// One slot of a sorted list. Compares the broadcast key, takes the new entry
// or the left neighbor's entry, and shifts left during readout.
// ----------------------------------------------------------------------------
module dsrl_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dsrl_pkg::cell_ctl_type    ctl,
   input  wire logic                      descending,
   input  wire logic                      left_valid,
   input  wire logic                      left_goes,
   input  wire logic [dsrl_pkg::ID_W-1:0] left_id,
   input  wire logic [dsrl_pkg::KEY_W-1:0] left_key,
   input  wire logic [dsrl_pkg::ID_W-1:0] right_id,
   input  wire logic [dsrl_pkg::KEY_W-1:0] right_key,
   output logic                           valid,
   output logic                           goes,
   output logic [dsrl_pkg::ID_W-1:0]      id,
   output logic [dsrl_pkg::KEY_W-1:0]     key
);
   import dsrl_pkg::*;

   logic             valid_ff, valid_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // goes: new entry sorts at or before this slot.
   always_comb begin
      goes = !valid_ff ||
             (descending ? !(key_ff > ctl.key) : !(key_ff < ctl.key));
      valid_in = valid_ff;
      id_in    = id_ff;
      key_in   = key_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (goes && left_goes) begin
            valid_in = left_valid;
            id_in    = left_id;
            key_in   = left_key;
         end else if (goes) begin
            valid_in = 1'b1;
            id_in    = ctl.id;
            key_in   = ctl.key;
         end
      end else if (ctl.shift) begin
         if (valid_ff) begin
            id_in  = right_id;
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff  <= id_in;
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign key   = key_ff;

endmodule
`default_nettype wire

// ===== rtl/dsrl_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_list
// A row of cells forming one bounded sorted list. Readout rotates the valid
// run so the head word leaves at cell 0 and returns behind the last entry.
// ----------------------------------------------------------------------------
module dsrl_list #(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dsrl_pkg::cell_ctl_type     ctl,
   input  wire logic                       descending,
   output logic                            tail_drop,
   output logic [$clog2(DEPTH+1)-1:0]      count,
   output logic [dsrl_pkg::ID_W-1:0]       head_id,
   output logic [dsrl_pkg::KEY_W-1:0]      head_key
);
   import dsrl_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]             v, g;
   logic [DEPTH-1:0][ID_W-1:0]   ids;
   logic [DEPTH-1:0][KEY_W-1:0]  keys;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int L = (i == 0) ? 0 : i - 1;
      localparam int R = (i == DEPTH - 1) ? 0 : i + 1;
      dsrl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .descending  (descending),
         .left_valid  (v[L]),
         .left_goes   ((i == 0) ? 1'b0 : g[L]),
         .left_id     (ids[L]),
         .left_key    (keys[L]),
         .right_id    (v[R] ? ids[R] : ids[0]),
         .right_key   (v[R] ? keys[R] : keys[0]),
         .valid       (v[i]),
         .goes        (g[i]),
         .id          (ids[i]),
         .key         (keys[i])
      );
   end

   always_comb begin
      count = CNT_W'(DEPTH);
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!v[i]) count = CNT_W'(i);
      end
   end

   assign tail_drop = v[DEPTH-1];
   assign head_id   = ids[0];
   assign head_key  = keys[0];

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth-sorted render list unit. Drives clear,
// insert, read and no-op words under random idling on both channels, predicts
// every response word from a behavioral copy of the lists, compares in order.
// ----------------------------------------------------------------------------
module tb;
   import dsrl_pkg::*;

   localparam int DEPTH  = 32;
   localparam int NLISTS = 6;

   typedef struct packed {
      logic [31:0] id;
      logic [33:0] key;
      logic [2:0]  status;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_req_type = '0;
   logic [31:0] req_mesh_id = '0;
   logic signed [15:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic        req_is_active = 0, req_is_visible = 0, req_has_material = 0;
   logic        req_is_transparent = 0, req_is_outlined = 0;
   logic [1:0]  req_outline_kind = '0;
   logic [2:0]  req_list_select = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_mesh_id;
   logic [33:0] rsp_out_distance;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   depth_sorted_render_lists_unit dut (.*);

   always #5 clock = ~clock;

   logic signed [15:0] cam [3];
   logic [31:0] list_ids [NLISTS][DEPTH];
   logic [33:0] list_keys [NLISTS][DEPTH];
   int          list_len [NLISTS];
   rsp_word_type pending_rsp [$];
   int          errors = 0;
   int          words_seen = 0;
   int          reqs_sent = 0;
   int          drops_seen = 0;
   int          rsp_wait = 0;
   bit          rsp_idle_on = 1'b1;

   function automatic logic [33:0] sq_dist(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
      longint dx, dy, dz;
      dx = longint'(x) - longint'(cam[0]);
      dy = longint'(y) - longint'(cam[1]);
      dz = longint'(z) - longint'(cam[2]);
      return 34'(dx * dx + dy * dy + dz * dz);
   endfunction

   function automatic bit file_entry(int l, logic [31:0] id, logic [33:0] key, bit desc);
      int pos, n;
      bit dropped;
      pos = 0;
      n = list_len[l];
      dropped = 0;
      while (pos < n && (desc ? list_keys[l][pos] > key : list_keys[l][pos] < key))
         pos++;
      if (n == DEPTH) begin
         dropped = 1;
         n = DEPTH - 1;
         if (pos >= DEPTH) return 1;
      end
      for (int i = n; i > pos; i--) begin
         list_ids[l][i] = list_ids[l][i-1];
         list_keys[l][i] = list_keys[l][i-1];
      end
      list_ids[l][pos] = id;
      list_keys[l][pos] = key;
      list_len[l] = n + 1;
      return dropped;
   endfunction

   task automatic predict_request();
      logic [33:0] key;
      bit dropped;
      int sel;
      case (req_kind_type'(req_req_type))
         REQ_CLEAR: begin
            foreach (list_len[i]) list_len[i] = 0;
            pending_rsp.push_back('{0, 0, ST_DONE, 1});
         end
         REQ_INSERT: begin
            if (!(req_is_active && req_is_visible && req_has_material)) begin
               pending_rsp.push_back('{0, 0, ST_SKIPPED, 1});
            end else begin
               key = sq_dist(req_center_x, req_center_y, req_center_z);
               dropped = req_is_transparent ? file_entry(1, req_mesh_id, key, 1)
                                            : file_entry(0, req_mesh_id, key, 0);
               if (req_is_outlined && file_entry(2 + req_outline_kind, req_mesh_id, key, 1))
                  dropped = 1;
               pending_rsp.push_back('{0, 0, dropped ? ST_DROPPED : ST_DONE, 1});
            end
         end
         REQ_READ: begin
            sel = req_list_select;
            if (sel >= NLISTS || list_len[sel] == 0) begin
               pending_rsp.push_back('{0, 0, ST_EMPTY, 1});
            end else begin
               for (int i = 0; i < list_len[sel]; i++)
                  pending_rsp.push_back('{list_ids[sel][i], list_keys[sel][i], ST_ENTRY,
                                          i + 1 == list_len[sel]});
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_word(logic [1:0] kind, logic [31:0] id, logic [15:0] x,
                            logic [15:0] y, logic [15:0] z, logic [4:0] flags,
                            logic [1:0] okind, logic [2:0] sel);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= kind;
      req_mesh_id <= id;
      req_center_x <= x;
      req_center_y <= y;
      req_center_z <= z;
      {req_is_active, req_is_visible, req_has_material, req_is_transparent,
       req_is_outlined} <= flags;
      req_outline_kind <= okind;
      req_list_select <= sel;
      do @(posedge clock); while (!req_ready);
      predict_request();
      reqs_sent++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_camera(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      logic [15:0] v [3];
      v = '{x, y, z};
      for (int i = 0; i < 3; i++) begin
         csr_write <= 1'b1;
         csr_index <= 2'(i);
         csr_data <= v[i];
         @(posedge clock);
         cam[i] = v[i];
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic insert_random(int id_span);
      send_word(REQ_INSERT, id_span == 0 ? $urandom : $urandom_range(0, id_span),
                16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(0, 5) == 0 ? 5'($urandom) : {3'b111, 2'($urandom)},
                2'($urandom), 0);
   endtask

   task automatic test_directed();
      send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
      send_word(REQ_INSERT, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 5'b11100, 0, 0);
      send_word(REQ_INSERT, 32'h0, 16'h8000, 16'h8000, 16'h8000, 5'b11101, 3, 0);
      send_word(REQ_INSERT, 32'h5, 16'h8000, 16'h8000, 16'h8000, 5'b11111, 0, 0);
      send_word(REQ_INSERT, 32'h6, 16'h0, 16'h0, 16'h0, 5'b11011, 1, 0);
      send_word(REQ_INSERT, 32'h7, 16'h0, 16'h0, 16'h0, 5'b11011, 2, 0);
      send_word(REQ_INSERT, 32'h8, 1, 2, 3, 5'b01111, 0, 0);
      send_word(REQ_INSERT, 32'h9, 1, 2, 3, 5'b10111, 0, 0);
      send_word(REQ_INSERT, 32'hA, 1, 2, 3, 5'b11011, 0, 0);
      for (int s = 0; s < 8; s++) send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 3'(s));
      send_word(REQ_NONE, 0, 0, 0, 0, 0, 0, 0);
      send_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < 40; i++)
         send_word(REQ_INSERT, i, 16'($urandom_range(0, 6)), 0, 0, 5'b11101, 0, 0);
      for (int i = 0; i < 36; i++)
         send_word(REQ_INSERT, 100 + i, 16'($urandom_range(0, 6)), 0, 0, 5'b11100, 0, 0);
      for (int s = 0; s < 3; s++) send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 3'(s));
      drain();
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0:       send_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
            1, 2, 3: send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 3'($urandom));
            4:       send_word(REQ_NONE, $urandom, 0, 0, 0, 0, 0, 3'($urandom));
            default: insert_random($urandom_range(0, 1) ? 0 : 15);
         endcase
      end
      for (int s = 0; s < NLISTS; s++) send_word(REQ_READ, 0, 0, 0, 0, 0, 0, 3'(s));
      drain();
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_word_type want;
            words_seen++;
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response word %h", rsp_out_mesh_id);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_status == ST_DROPPED) drops_seen++;
               if (want != {rsp_out_mesh_id, rsp_out_distance, rsp_status, rsp_last}) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp id=%h d=%h st=%0d l=%b got id=%h d=%h st=%0d l=%b",
                              want.id, want.key, want.status, want.last, rsp_out_mesh_id,
                              rsp_out_distance, rsp_status, rsp_last);
               end
            end
            rsp_wait = rsp_idle_on ? $urandom_range(0, 10) : 0;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("FAIL depth_sorted_render_lists_unit");
      $finish;
   end

   initial begin
      cam = '{0, 0, 0};
      foreach (list_len[i]) list_len[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_camera(16'h7FFF, 16'h7FFF, 16'h7FFF);
      test_directed();
      write_camera(16'h8000, 16'h8000, 16'h8000);
      test_overflow();
      test_directed();
      rsp_idle_on = 1'b0;
      write_camera(16'($urandom), 16'($urandom), 16'($urandom));
      test_random(50);
      rsp_idle_on = 1'b1;
      write_camera(16'($urandom), 16'($urandom), 16'($urandom));
      test_random(100);
      $display("covered %0d requests, %0d response words, %0d tail drops",
               reqs_sent, words_seen, drops_seen);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS depth_sorted_render_lists_unit");
      end else begin
         $display("%0d mismatches, %0d words outstanding", errors, pending_rsp.size());
         $display("FAIL depth_sorted_render_lists_unit");
      end
      $finish;
   end
endmodule
